// ===== rtl/cdl_pkg.sv =====
// cdl_pkg: shared types, codes and helpers for the cyclic dominance lattice block
// used by the channel interfaces, the event rule logic and the top level
package cdl_pkg;

    localparam int SITES_DEFAULT = 12;
    localparam int RATE_W        = 17;
    localparam int RAND_W        = 16;
    localparam int SPECIES_W     = 2;
    localparam int SITE_W        = 4;
    localparam int COUNT_W       = 4;
    localparam int TOTAL_W       = 32;
    localparam int CFG_INDEX_W   = 3;

    localparam logic [RATE_W-1:0] RATE_RESET = 17'h10000;

    typedef logic [SPECIES_W-1:0] species_t;
    typedef logic [RATE_W-1:0]    rate_t;
    typedef logic [RAND_W-1:0]    rand_t;

    localparam species_t SP_EMPTY = 2'd0;
    localparam species_t SP_A     = 2'd1;
    localparam species_t SP_B     = 2'd2;
    localparam species_t SP_C     = 2'd3;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_SWITCH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEATH_A = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEATH_B = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEATH_C = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BIRTH_A = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BIRTH_B = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BIRTH_C = 3'd6;

    typedef struct packed {
        logic                action;
        logic [SITE_W-1:0]   site;
        species_t            load_species;
        logic                direction;
        logic [2:0]          event_bits;
        rand_t               rand_switch;
        rand_t               rand_death;
        rand_t               rand_birth;
        rand_t               rand_switch_second;
        rand_t               rand_birth_second;
        rand_t               rand_switch_third;
        rand_t               rand_birth_third;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  count_a;
        logic [COUNT_W-1:0]  count_b;
        logic [COUNT_W-1:0]  count_c;
        logic                dominated;
        species_t            winner;
        logic [TOTAL_W-1:0]  sweep_count;
    } out_item_t;

    // new site values and population bookkeeping for one event
    typedef struct packed {
        species_t new_x;
        species_t new_nb;
        logic     inc_en;
        species_t inc_sp;
        logic     dec_en;
        species_t dec_sp;
    } rule_res_t;

    function automatic logic rate_pass(input rand_t r, input rate_t rate);
        return {1'b0, r} <= rate;
    endfunction

    function automatic species_t prey_of(input species_t s);
        species_t p;
        case (s)
            SP_A:    p = SP_B;
            SP_B:    p = SP_C;
            SP_C:    p = SP_A;
            default: p = SP_EMPTY;
        endcase
        return p;
    endfunction

    function automatic species_t pred_of(input species_t s);
        species_t p;
        case (s)
            SP_A:    p = SP_C;
            SP_B:    p = SP_A;
            SP_C:    p = SP_B;
            default: p = SP_EMPTY;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/cdl_in_if.sv =====
// cdl_in_if: valid/ready channel carrying one input item per beat
// depends on cdl_pkg for the payload type
interface cdl_in_if;
    import cdl_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cdl_out_if.sv =====
// cdl_out_if: valid/ready channel carrying one result item per beat
// depends on cdl_pkg for the payload type
interface cdl_out_if;
    import cdl_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cyclic_dominance_lattice_step.sv =====
// cyclic_dominance_lattice_step: ring lattice of species with cyclic predation
// the result is registered after the calc and wr2 states; input waits until it is loaded
// the lattice memory is read at the input beat, written back in the calc and wr2 states
// reset: rates to 65536, counts zero, then a clearing pass through every site
// writes each one empty; no input beat is taken during that pass
// depends on cdl_pkg, cdl_in_if, cdl_out_if and cdl_rules
module cyclic_dominance_lattice_step #(
    parameter int SITES = cdl_pkg::SITES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    cdl_in_if.sink                           in_ch,
    cdl_out_if.source                        out_ch,
    input  logic                             cfg_we,
    input  logic [cdl_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cdl_pkg::RATE_W-1:0]       cfg_data
);
    import cdl_pkg::*;

    localparam int AW = $clog2(SITES);
    localparam int PW = $clog2(SITES + 1);

    localparam logic [AW-1:0] LAST_SITE = AW'(SITES - 1);
    localparam logic [PW-1:0] FULL_POP  = PW'(SITES);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_CALC = 3'd2;
    localparam logic [2:0] ST_WR2  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       clr_cnt_reg;
    species_t            lattice_mem [SITES];
    species_t            rd_x_reg, rd_nb_reg;
    in_item_t            item_reg;
    logic                site_ok_reg;
    logic [AW-1:0]       x_addr_reg, nb_addr_reg;
    species_t            new_nb_reg;

    rate_t               switch_rate_reg;
    rate_t               death_rate_reg [3];
    rate_t               birth_rate_reg [3];
    logic [PW-1:0]       population_reg [3];
    logic [TOTAL_W-1:0]  event_total_reg;
    logic [TOTAL_W-1:0]  sweep_reg;
    logic [AW-1:0]       rem_reg;

    logic                out_valid_reg;
    out_item_t           out_data_reg;

    logic                accept;
    logic                site_ok;
    logic [AW-1:0]       x_addr, nb_addr;
    logic [2:0]          pop_nonzero;
    rule_res_t           rule_res;
    logic                out_free;
    logic                out_load;
    out_item_t           result;

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign accept       = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;
    assign out_free     = !out_valid_reg || out_ch.ready;

    // site index check and neighbour address
    always_comb
    begin
        logic [TOTAL_W-1:0] site_wide;
        site_wide = TOTAL_W'(in_ch.data.site);
        site_ok   = site_wide < TOTAL_W'(SITES);
        x_addr    = site_ok ? site_wide[AW-1:0] : '0;
        if (in_ch.data.direction)
            nb_addr = (x_addr == '0) ? LAST_SITE : AW'(x_addr - 1'b1);
        else
            nb_addr = (x_addr == LAST_SITE) ? '0 : AW'(x_addr + 1'b1);
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            pop_nonzero[k] = (population_reg[k] != '0);
    end

    cdl_rules u_rules (
        .item        (item_reg),
        .me          (rd_x_reg),
        .other       (rd_nb_reg),
        .switch_rate (switch_rate_reg),
        .death_rate  (death_rate_reg),
        .birth_rate  (birth_rate_reg),
        .pop_nonzero (pop_nonzero),
        .res         (rule_res)
    );

    // lattice memory: two read ports at the input beat, one write port
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_x_reg  <= lattice_mem[x_addr];
            rd_nb_reg <= lattice_mem[nb_addr];
        end
        if (state_reg == ST_CLR)
            lattice_mem[clr_cnt_reg] <= SP_EMPTY;
        else if (state_reg == ST_CALC && site_ok_reg)
            lattice_mem[x_addr_reg] <= rule_res.new_x;
        else if (state_reg == ST_WR2 && site_ok_reg && item_reg.action == ACT_STEP)
            lattice_mem[nb_addr_reg] <= new_nb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg    <= in_ch.data;
            site_ok_reg <= site_ok;
            x_addr_reg  <= x_addr;
            nb_addr_reg <= nb_addr;
        end
        if (state_reg == ST_CALC)
            new_nb_reg <= rule_res.new_nb;
    end

    // result from the updated counts
    always_comb
    begin
        species_t win;
        win = SP_EMPTY;
        for (int k = 0; k < 3; k++)
            if (population_reg[k] == FULL_POP)
                win = species_t'(k + 1);
        result.count_a     = COUNT_W'(population_reg[0]);
        result.count_b     = COUNT_W'(population_reg[1]);
        result.count_c     = COUNT_W'(population_reg[2]);
        result.dominated   = (win != SP_EMPTY);
        result.winner      = win;
        result.sweep_count = sweep_reg;
    end

    assign out_load = (state_reg == ST_WR2 || state_reg == ST_DONE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR:  if (clr_cnt_reg == LAST_SITE) state_next = ST_IDLE;
            ST_IDLE: if (accept) state_next = ST_CALC;
            ST_CALC: state_next = ST_WR2;
            ST_WR2:  state_next = out_free ? ST_IDLE : ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_CLR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLR;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            switch_rate_reg <= RATE_RESET;
            for (int k = 0; k < 3; k++)
            begin
                death_rate_reg[k] <= RATE_RESET;
                birth_rate_reg[k] <= RATE_RESET;
                population_reg[k] <= '0;
            end
            event_total_reg <= '0;
            sweep_reg       <= '0;
            rem_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_CLR)
                clr_cnt_reg <= AW'(clr_cnt_reg + 1'b1);

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SWITCH:  switch_rate_reg   <= cfg_data;
                    REG_DEATH_A: death_rate_reg[0] <= cfg_data;
                    REG_DEATH_B: death_rate_reg[1] <= cfg_data;
                    REG_DEATH_C: death_rate_reg[2] <= cfg_data;
                    REG_BIRTH_A: birth_rate_reg[0] <= cfg_data;
                    REG_BIRTH_B: birth_rate_reg[1] <= cfg_data;
                    REG_BIRTH_C: birth_rate_reg[2] <= cfg_data;
                    default:     ;
                endcase
            end

            if (state_reg == ST_CALC && site_ok_reg)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    logic [PW-1:0] p1;
                    p1 = population_reg[k];
                    if (rule_res.dec_en && rule_res.dec_sp == species_t'(k + 1) && p1 != '0)
                        p1 = PW'(p1 - 1'b1);
                    if (rule_res.inc_en && rule_res.inc_sp == species_t'(k + 1) &&
                        p1 != FULL_POP)
                        p1 = PW'(p1 + 1'b1);
                    population_reg[k] <= p1;
                end
                // event count with a running sweep quotient
                if (item_reg.action == ACT_STEP && event_total_reg != '1)
                begin
                    event_total_reg <= TOTAL_W'(event_total_reg + 1'b1);
                    if (rem_reg == LAST_SITE)
                    begin
                        rem_reg   <= '0;
                        sweep_reg <= TOTAL_W'(sweep_reg + 1'b1);
                    end
                    else
                        rem_reg <= AW'(rem_reg + 1'b1);
                end
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= result;
    end
endmodule

// ===== rtl/cdl_rules.sv =====
// cdl_rules: event rules for one picked site and its neighbour
// depends on cdl_pkg; purely combinational, fed from the lattice read registers
module cdl_rules (
    input  cdl_pkg::in_item_t  item,
    input  cdl_pkg::species_t  me,
    input  cdl_pkg::species_t  other,
    input  cdl_pkg::rate_t     switch_rate,
    input  cdl_pkg::rate_t     death_rate [3],
    input  cdl_pkg::rate_t     birth_rate [3],
    input  logic [2:0]         pop_nonzero,
    output cdl_pkg::rule_res_t res
);
    import cdl_pkg::*;

    always_comb
    begin
        species_t prey;
        species_t pred;
        species_t cur_x;
        species_t cur_nb;
        species_t trial_sp [3];
        logic     trial_bit [3];
        rand_t    trial_rs [3];
        rand_t    trial_rb [3];
        logic [1:0] me_idx;
        logic [1:0] prey_idx;
        logic [1:0] sp_idx;

        prey   = prey_of(me);
        pred   = pred_of(me);
        me_idx   = 2'(me - SP_A);
        prey_idx = 2'(prey - SP_A);
        sp_idx   = 2'd0;
        cur_x  = me;
        cur_nb = other;

        trial_sp[0]  = SP_A;
        trial_sp[1]  = SP_C;
        trial_sp[2]  = SP_B;
        trial_bit[0] = item.event_bits[0];
        trial_bit[1] = item.event_bits[1];
        trial_bit[2] = item.event_bits[2];
        trial_rs[0]  = item.rand_switch;
        trial_rs[1]  = item.rand_switch_second;
        trial_rs[2]  = item.rand_switch_third;
        trial_rb[0]  = item.rand_birth;
        trial_rb[1]  = item.rand_birth_second;
        trial_rb[2]  = item.rand_birth_third;

        res.new_x  = me;
        res.new_nb = other;
        res.inc_en = 1'b0;
        res.inc_sp = SP_EMPTY;
        res.dec_en = 1'b0;
        res.dec_sp = SP_EMPTY;

        if (item.action == ACT_LOAD)
        begin
            res.new_x  = item.load_species;
            res.dec_en = (me != SP_EMPTY);
            res.dec_sp = me;
            res.inc_en = (item.load_species != SP_EMPTY);
            res.inc_sp = item.load_species;
        end
        else if (me != SP_EMPTY)
        begin
            if (other == prey || other == pred)
            begin
                if (!item.event_bits[0])
                begin
                    if (rate_pass(item.rand_switch, switch_rate))
                    begin
                        res.new_x  = other;
                        res.new_nb = me;
                    end
                end
                else if (other == prey)
                begin
                    if (pop_nonzero[prey_idx] &&
                        rate_pass(item.rand_death, death_rate[prey_idx]))
                    begin
                        res.new_nb = SP_EMPTY;
                        res.dec_en = 1'b1;
                        res.dec_sp = prey;
                    end
                end
                else
                begin
                    if (pop_nonzero[me_idx] &&
                        rate_pass(item.rand_death, death_rate[me_idx]))
                    begin
                        res.new_x  = SP_EMPTY;
                        res.dec_en = 1'b1;
                        res.dec_sp = me;
                    end
                end
            end
            else if (other == SP_EMPTY)
            begin
                if (!item.event_bits[0])
                begin
                    if (rate_pass(item.rand_switch, switch_rate))
                    begin
                        res.new_x  = SP_EMPTY;
                        res.new_nb = me;
                    end
                end
                else if (rate_pass(item.rand_birth, birth_rate[me_idx]))
                begin
                    res.new_nb = me;
                    res.inc_en = 1'b1;
                    res.inc_sp = me;
                end
            end
        end
        else
        begin
            // sub-trials a, c, b; each only while the site is still empty
            for (int k = 0; k < 3; k++)
            begin
                sp_idx = 2'(trial_sp[k] - SP_A);
                if (cur_x == SP_EMPTY && cur_nb == trial_sp[k])
                begin
                    if (!trial_bit[k])
                    begin
                        if (rate_pass(trial_rs[k], switch_rate))
                        begin
                            cur_x  = trial_sp[k];
                            cur_nb = SP_EMPTY;
                        end
                    end
                    else if (rate_pass(trial_rb[k], birth_rate[sp_idx]))
                    begin
                        cur_x      = trial_sp[k];
                        res.inc_en = 1'b1;
                        res.inc_sp = trial_sp[k];
                    end
                end
            end
            res.new_x  = cur_x;
            res.new_nb = cur_nb;
        end
    end
endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for cyclic_dominance_lattice_step
// drives load and step beats, predicts species counts and sweeps, checks every result beat
// depends on cdl_pkg, cdl_in_if, cdl_out_if and the rtl top level
module testbench;
    import cdl_pkg::*;

    localparam int SITES       = SITES_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 90;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 135;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    rate_t                  cfg_data;

    cdl_in_if  in_ch ();
    cdl_out_if out_ch ();

    cyclic_dominance_lattice_step #(.SITES(SITES)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // lattice mirror and rate copies
    species_t           lattice [SITES];
    logic [COUNT_W-1:0] census [3];
    logic [TOTAL_W-1:0] events_seen;
    rate_t              swap_thr;
    rate_t              death_thr [3];
    rate_t              birth_thr [3];

    in_item_t  lattice_cmds [$];
    out_item_t predicted_counts [$];
    out_item_t predicted_now;

    int items_sent  = 0;
    int items_taken = 0;
    int mismatches  = 0;
    int cycles      = 0;
    int send_gap    = 0;
    int take_gap    = 0;
    int hold_left   = 0;
    bit hold_kick   = 1'b0;
    bit no_idle     = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit passes(input rand_t r, input rate_t thr);
        return {1'b0, r} <= thr;
    endfunction

    task automatic census_down(input species_t s);
        if (s != SP_EMPTY && census[int'(s) - 1] != 0)
            census[int'(s) - 1]--;
    endtask

    task automatic census_up(input species_t s);
        if (s != SP_EMPTY && census[int'(s) - 1] < SITES)
            census[int'(s) - 1]++;
    endtask

    // one sub-trial on an empty site: the neighbour of species sp moves or breeds in
    task automatic colonise(input int x, input int nb, input species_t sp, input logic breed,
                            input rand_t rs, input rand_t rb);
        if (lattice[x] == SP_EMPTY && lattice[nb] == sp)
        begin
            if (!breed)
            begin
                if (passes(rs, swap_thr))
                begin
                    lattice[x] = sp;
                    lattice[nb] = SP_EMPTY;
                end
            end
            else if (passes(rb, birth_thr[int'(sp) - 1]))
            begin
                lattice[x] = sp;
                census_up(sp);
            end
        end
    endtask

    task automatic advance_lattice(input in_item_t it, output out_item_t res);
        int       x;
        int       nb;
        int       k;
        species_t me;
        species_t other;
        species_t victim;
        species_t hunter;
        species_t win;
        x = int'(it.site);
        win = SP_EMPTY;
        if (x < SITES)
        begin
            if (it.action == ACT_LOAD)
            begin
                census_down(lattice[x]);
                lattice[x] = it.load_species;
                census_up(it.load_species);
            end
            else
            begin
                nb = it.direction ? (x + SITES - 1) % SITES : (x + 1) % SITES;
                me = lattice[x];
                other = lattice[nb];
                if (events_seen != '1)
                    events_seen++;
                if (me != SP_EMPTY)
                begin
                    victim = species_t'(int'(me) % 3 + 1);
                    hunter = species_t'((int'(me) + 1) % 3 + 1);
                    if (other == victim || other == hunter)
                    begin
                        if (!it.event_bits[0])
                        begin
                            if (passes(it.rand_switch, swap_thr))
                            begin
                                lattice[x] = other;
                                lattice[nb] = me;
                            end
                        end
                        else if (other == victim)
                        begin
                            if (census[int'(victim) - 1] != 0
                                && passes(it.rand_death, death_thr[int'(victim) - 1]))
                            begin
                                lattice[nb] = SP_EMPTY;
                                census_down(victim);
                            end
                        end
                        else if (census[int'(me) - 1] != 0
                                 && passes(it.rand_death, death_thr[int'(me) - 1]))
                        begin
                            lattice[x] = SP_EMPTY;
                            census_down(me);
                        end
                    end
                    else if (other == SP_EMPTY)
                    begin
                        if (!it.event_bits[0])
                        begin
                            if (passes(it.rand_switch, swap_thr))
                            begin
                                lattice[x] = SP_EMPTY;
                                lattice[nb] = me;
                            end
                        end
                        else if (passes(it.rand_birth, birth_thr[int'(me) - 1]))
                        begin
                            lattice[nb] = me;
                            census_up(me);
                        end
                    end
                end
                else
                begin
                    colonise(x, nb, SP_A, it.event_bits[0], it.rand_switch, it.rand_birth);
                    colonise(x, nb, SP_C, it.event_bits[1], it.rand_switch_second,
                             it.rand_birth_second);
                    colonise(x, nb, SP_B, it.event_bits[2], it.rand_switch_third,
                             it.rand_birth_third);
                end
            end
        end
        for (k = 0; k < 3; k++)
            if (census[k] == SITES)
                win = species_t'(k + 1);
        res.count_a     = census[0];
        res.count_b     = census[1];
        res.count_c     = census[2];
        res.dominated   = (win != SP_EMPTY);
        res.winner      = win;
        res.sweep_count = events_seen / SITES;
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
        $display("mismatch in %s: got %0d, expected %0d", what, got_v, want_v);
        mismatches++;
    endtask

    task automatic check_counts(input out_item_t got);
        out_item_t want;
        if (predicted_counts.size() == 0)
            flag_mismatch("result beat with nothing pending", got.sweep_count, 0);
        else
        begin
            want = predicted_counts.pop_front();
            if (got.count_a !== want.count_a)
                flag_mismatch("count_a", 32'(got.count_a), 32'(want.count_a));
            if (got.count_b !== want.count_b)
                flag_mismatch("count_b", 32'(got.count_b), 32'(want.count_b));
            if (got.count_c !== want.count_c)
                flag_mismatch("count_c", 32'(got.count_c), 32'(want.count_c));
            if (got.dominated !== want.dominated)
                flag_mismatch("dominated", 32'(got.dominated), 32'(want.dominated));
            if (got.winner !== want.winner)
                flag_mismatch("winner", 32'(got.winner), 32'(want.winner));
            if (got.sweep_count !== want.sweep_count)
                flag_mismatch("sweep_count", got.sweep_count, want.sweep_count);
        end
    endtask

    // mostly no gap, some short, a few long
    function automatic int idle_len();
        int p;
        if (no_idle)
            return 0;
        p = $urandom_range(99);
        if (p < 60)
            return 0;
        if (p < 93)
            return $urandom_range(3, 1);
        return $urandom_range(24, 8);
    endfunction

    function automatic in_item_t noise_item();
        logic [127:0] bits;
        in_item_t     it;
        bits = {$urandom, $urandom, $urandom, $urandom};
        it = bits[$bits(in_item_t)-1:0];
        return it;
    endfunction

    function automatic in_item_t load_cmd(input int s, input species_t sp);
        in_item_t it;
        it = noise_item();
        it.action = ACT_LOAD;
        it.site = s[SITE_W-1:0];
        it.load_species = sp;
        return it;
    endfunction

    function automatic in_item_t step_cmd(input int s, input logic dir, input logic [2:0] ev,
                                          input rand_t r);
        in_item_t it;
        it = noise_item();
        it.action = ACT_STEP;
        it.site = s[SITE_W-1:0];
        it.direction = dir;
        it.event_bits = ev;
        it.rand_switch = r;
        it.rand_death = r;
        it.rand_birth = r;
        it.rand_switch_second = r;
        it.rand_birth_second = r;
        it.rand_switch_third = r;
        it.rand_birth_third = r;
        return it;
    endfunction

    // random draw, biased towards the rate boundary and the extremes
    function automatic rand_t near_rate(input rate_t thr);
        int p;
        int v;
        p = $urandom_range(9);
        if (p < 5)
            return rand_t'($urandom);
        if (p == 5)
            return '0;
        if (p == 6)
            return '1;
        v = int'(thr) + int'($urandom_range(4)) - 2;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return rand_t'(v);
    endfunction

    function automatic rate_t pick_rate(input int ph, input bit is_switch);
        case (ph)
            1: return '0;
            2: return rate_t'($urandom_range(131071));
            3: return 17'd65535;
            4: return rate_t'($urandom_range(65536));
            5: return is_switch ? '0 : RATE_RESET;
            6: return is_switch ? RATE_RESET : 17'd1;
            7: return '1;
            default: return RATE_RESET;
        endcase
    endfunction

    task automatic queue_cmd(input in_item_t it);
        lattice_cmds.push_back(it);
        items_sent++;
    endtask

    task automatic write_rate(input logic [CFG_INDEX_W-1:0] idx, input rate_t v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            REG_SWITCH:  swap_thr = v;
            REG_DEATH_A: death_thr[0] = v;
            REG_DEATH_B: death_thr[1] = v;
            REG_DEATH_C: death_thr[2] = v;
            REG_BIRTH_A: birth_thr[0] = v;
            REG_BIRTH_B: birth_thr[1] = v;
            REG_BIRTH_C: birth_thr[2] = v;
            default: ;
        endcase
    endtask

    task automatic settle();
        while (items_taken != items_sent || predicted_counts.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // sender: offers queued beats, predicts on acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                advance_lattice(in_ch.data, predicted_now);
                predicted_counts.push_back(predicted_now);
                items_taken++;
            end
            if (in_ch.valid && !in_ch.ready)
                ;
            else if (send_gap != 0)
            begin
                in_ch.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (lattice_cmds.size() != 0)
            begin
                in_ch.valid <= 1'b1;
                in_ch.data <= lattice_cmds.pop_front();
                send_gap <= idle_len();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // receiver: random stalls plus the long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            take_gap <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                check_counts(out_ch.data);
            if (hold_left != 0)
                out_ch.ready <= 1'b0;
            else if (take_gap != 0)
            begin
                out_ch.ready <= 1'b0;
                take_gap <= take_gap - 1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                take_gap <= idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_kick)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int       ph;
        int       budget;
        int       mode;
        int       n;
        int       k;
        species_t sp;
        species_t alt;
        in_item_t it;

        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SWITCH;
        cfg_data = '0;
        for (k = 0; k < SITES; k++)
            lattice[k] = SP_EMPTY;
        for (k = 0; k < 3; k++)
        begin
            census[k] = '0;
            death_thr[k] = RATE_RESET;
            birth_thr[k] = RATE_RESET;
        end
        swap_thr = RATE_RESET;
        events_seen = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed walk through the rules at reset rates
        queue_cmd(load_cmd(0, SP_A));
        queue_cmd(load_cmd(1, SP_B));
        queue_cmd(step_cmd(0, 1'b0, 3'b000, 16'hFFFF));
        queue_cmd(step_cmd(0, 1'b0, 3'b001, 16'h0001));
        queue_cmd(load_cmd(11, SP_C));
        queue_cmd(step_cmd(0, 1'b1, 3'b111, 16'h0000));
        queue_cmd(step_cmd(0, 1'b0, 3'b001, 16'h8000));
        queue_cmd(step_cmd(0, 1'b0, 3'b001, 16'hFFFF));
        queue_cmd(step_cmd(1, 1'b0, 3'b000, 16'h0001));
        queue_cmd(step_cmd(1, 1'b0, 3'b010, 16'h7FFF));
        queue_cmd(step_cmd(1, 1'b1, 3'b000, 16'hFFFF));
        queue_cmd(load_cmd(5, SP_B));
        queue_cmd(step_cmd(4, 1'b0, 3'b000, 16'h1234));
        queue_cmd(load_cmd(11, SP_A));
        queue_cmd(step_cmd(10, 1'b0, 3'b000, 16'hFFFF));
        queue_cmd(step_cmd(11, 1'b0, 3'b001, 16'hFFFF));
        queue_cmd(load_cmd(12, SP_A));
        queue_cmd(step_cmd(15, 1'b1, 3'b111, 16'hFFFF));
        queue_cmd(load_cmd(3, SP_EMPTY));
        queue_cmd(step_cmd(3, 1'b1, 3'b100, 16'hFFFF));
        queue_cmd(step_cmd(2, 1'b0, 3'b110, 16'hFFFF));
        settle();

        for (ph = 0; ph < PHASES; ph++)
        begin
            write_rate(REG_SWITCH, pick_rate(ph, 1'b1));
            write_rate(REG_DEATH_A, pick_rate(ph, 1'b0));
            write_rate(REG_DEATH_B, pick_rate(ph, 1'b0));
            write_rate(REG_DEATH_C, pick_rate(ph, 1'b0));
            write_rate(REG_BIRTH_A, pick_rate(ph, 1'b0));
            write_rate(REG_BIRTH_B, pick_rate(ph, 1'b0));
            write_rate(REG_BIRTH_C, pick_rate(ph, 1'b0));
            @(posedge clk);
            cfg_we <= 1'b0;
            no_idle = (ph == 3);
            budget = 0;
            while (budget < PHASE_ITEMS)
            begin
                // fresh lattice fill, then a burst of events on it
                mode = $urandom_range(3);
                sp = species_t'($urandom_range(3, 1));
                alt = species_t'($urandom_range(3, 1));
                for (k = 0; k < SITES; k++)
                    case (mode)
                        0: queue_cmd(load_cmd(k, sp));
                        1: queue_cmd(load_cmd(k, species_t'($urandom_range(3))));
                        2: queue_cmd(load_cmd(k, $urandom_range(1) ? sp : alt));
                        default: queue_cmd(load_cmd(k, $urandom_range(3) == 0 ? sp : SP_EMPTY));
                    endcase
                budget += SITES;
                n = $urandom_range(40, 12);
                repeat (n)
                begin
                    if ($urandom_range(9) == 0)
                        it = load_cmd($urandom_range(15), species_t'($urandom_range(3)));
                    else
                    begin
                        it = noise_item();
                        it.action = ACT_STEP;
                        it.site = ($urandom_range(19) == 0) ? SITE_W'($urandom_range(15, 12))
                                                             : SITE_W'($urandom_range(SITES - 1));
                        it.rand_switch = near_rate(swap_thr);
                        it.rand_death = near_rate(death_thr[$urandom_range(2)]);
                        it.rand_birth = near_rate(birth_thr[$urandom_range(2)]);
                        it.rand_switch_second = near_rate(swap_thr);
                        it.rand_birth_second = near_rate(birth_thr[2]);
                        it.rand_switch_third = near_rate(swap_thr);
                        it.rand_birth_third = near_rate(birth_thr[1]);
                    end
                    if (it.site < SITES)
                        budget++;
                    queue_cmd(it);
                end
            end
            if (ph == 2)
            begin
                // sender keeps offering while the receiver holds off
                @(posedge clk);
                hold_kick <= 1'b1;
                @(posedge clk);
                hold_kick <= 1'b0;
            end
            settle();
        end

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cdl_pkg.sv
rtl/cdl_in_if.sv
rtl/cdl_out_if.sv
rtl/cdl_rules.sv
rtl/cyclic_dominance_lattice_step.sv
dv/testbench.sv
